@@ rtl/bez_pkg.sv @@
`default_nettype none
package bez_pkg;

   // grid memory
   localparam int GRID_WORDS = 65536;
   localparam int GRID_AW    = $clog2(GRID_WORDS);
   localparam int ELEV_W     = 16;

   // coordinate and divider widths
   localparam int COORD_W   = 24;
   localparam int FRAC_W    = 16;
   localparam int QUOT_W    = COORD_W + FRAC_W;
   localparam int DIV_STEPS = QUOT_W;
   localparam int DIV_ST_W  = COORD_W + QUOT_W;

   // weights and patched corners (corners held as six times their value)
   localparam int WEIGHT_W = 2 * (FRAC_W + 1) - 1;
   localparam int PE_W     = ELEV_W + 3;
   localparam int PROD_W   = WEIGHT_W + 1 + PE_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int MAG_W    = 26;
   localparam int OUT_W    = 24;

   // floor(m / 6) = (m * RECIP6) >> RECIP_SHIFT for m below 2**31
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 30;
   localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);

   // register stages: input, divider, cell/address/read, interpolation
   localparam int INTERP_STAGES = 6;
   localparam int LATENCY       = 1 + DIV_STEPS + 3 + INTERP_STAGES;

   typedef enum logic [2:0] {
      CSR_CELL_WIDTH      = 3'd0,
      CSR_CELL_HEIGHT     = 3'd1,
      CSR_REGION_TOP      = 3'd2,
      CSR_DRAWABLE_COLS   = 3'd3,
      CSR_DRAWABLE_ROWS   = 3'd4,
      CSR_COL_SKIP        = 3'd5,
      CSR_CELL_ROW_STRIDE = 3'd6,
      CSR_ZERO_FILL       = 3'd7
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // word carried alongside the divider
   typedef struct packed {
      logic                     mode;
      logic [GRID_AW-1:0]       addr;
      logic signed [ELEV_W-1:0] word;
      logic                     miss;
   } tag_type;

   // control handed to the interpolation pipe
   typedef struct packed {
      logic valid;
      logic query;
      logic miss;
   } ctl_type;

endpackage
`default_nettype wire

@@ rtl/bilinear_elevation_zero_fill.sv @@
// a query's result comes out after the input, divider, cell, address, read and interpolation registers
// throughput: one word per cycle, loads and queries mixed freely; busy stays low
// the 40-step quotient pipe (one quotient bit per stage) sets the depth; the four
// corner reads go to four copies of the grid, each read once per cycle
// reset (synchronous, active high) restores the registers and empties the pipe;
// grid contents are kept and unwritten words read as unknown
`default_nettype none
module bilinear_elevation_zero_fill (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_mode,
   input  wire logic [15:0]                     req_grid_address,
   input  wire logic signed [15:0]              req_elevation_word,
   input  wire logic [23:0]                     req_x_pos,
   input  wire logic [23:0]                     req_y_pos,
   output logic                                 rsp_valid,
   output logic                                 rsp_inside_ok,
   output logic signed [23:0]                   rsp_elevation_q8,
   input  wire logic                            csr_we,
   input  wire logic [2:0]                      csr_index,
   input  wire logic [23:0]                     csr_wdata
);
   localparam int CW = bez_pkg::COORD_W;
   localparam int FW = bez_pkg::FRAC_W;
   localparam int QW = bez_pkg::QUOT_W;
   localparam int GA = bez_pkg::GRID_AW;
   localparam int WW = bez_pkg::WEIGHT_W;

   // configuration registers
   logic [CW-1:0] cell_width_ff;
   logic [CW-1:0] cell_height_ff;
   logic [CW-1:0] region_top_ff;
   logic [15:0]   drawable_cols_ff;
   logic [15:0]   drawable_rows_ff;
   logic [7:0]    col_skip_ff;
   logic [15:0]   cell_row_stride_ff;
   logic          zero_fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff      <= CW'(256);
         cell_height_ff     <= CW'(256);
         region_top_ff      <= '0;
         drawable_cols_ff   <= '0;
         drawable_rows_ff   <= '0;
         col_skip_ff        <= 8'd1;
         cell_row_stride_ff <= 16'd1;
         zero_fill_ff       <= 1'b0;
      end else if (csr_we) begin
         unique case (bez_pkg::csr_index_type'(csr_index))
            bez_pkg::CSR_CELL_WIDTH:      cell_width_ff      <= csr_wdata;
            bez_pkg::CSR_CELL_HEIGHT:     cell_height_ff     <= csr_wdata;
            bez_pkg::CSR_REGION_TOP:      region_top_ff      <= csr_wdata;
            bez_pkg::CSR_DRAWABLE_COLS:   drawable_cols_ff   <= csr_wdata[15:0];
            bez_pkg::CSR_DRAWABLE_ROWS:   drawable_rows_ff   <= csr_wdata[15:0];
            bez_pkg::CSR_COL_SKIP:        col_skip_ff        <= csr_wdata[7:0];
            bez_pkg::CSR_CELL_ROW_STRIDE: cell_row_stride_ff <= csr_wdata[15:0];
            bez_pkg::CSR_ZERO_FILL:       zero_fill_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // the pipe never stalls, so a word is taken whenever start is high
   assign busy = 1'b0;

   // input stage: distance below region top and early miss
   logic             s0_valid_ff;
   bez_pkg::tag_type s0_tag_ff;
   logic [CW-1:0]    s0_x_ff;
   logic [CW-1:0]    s0_d_ff;
   bez_pkg::tag_type s0_tag_in;

   always_comb begin
      s0_tag_in.mode = req_mode;
      s0_tag_in.addr = req_grid_address;
      s0_tag_in.word = req_elevation_word;
      s0_tag_in.miss = (cell_width_ff == '0) || (cell_height_ff == '0)
                       || (req_y_pos > region_top_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
      s0_tag_ff <= s0_tag_in;
      s0_x_ff   <= req_x_pos;
      s0_d_ff   <= region_top_ff - req_y_pos;
   end

   // quotient pipe: (x << 16) / cell_width gives column and x weight at once, likewise for top - y
   logic             dv_valid;
   bez_pkg::tag_type dv_tag;
   logic [QW-1:0]    x_quot;
   logic [QW-1:0]    y_quot;

   bez_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s0_valid_ff),
      .in_tag     (s0_tag_ff),
      .x_num      (s0_x_ff),
      .y_num      (s0_d_ff),
      .cell_width (cell_width_ff),
      .cell_height(cell_height_ff),
      .out_valid  (dv_valid),
      .out_tag    (dv_tag),
      .x_quot     (x_quot),
      .y_quot     (y_quot)
   );

   // cell stage: drawable check, low row/column offsets, complementary weights
   logic [CW-1:0]    col;
   logic [CW-1:0]    row;
   logic             cell_miss;

   assign col       = x_quot[QW-1:FW];
   assign row       = y_quot[QW-1:FW];
   assign cell_miss = (({1'b0, col} + (CW+1)'(2)) > (CW+1)'(drawable_cols_ff))
                      || (({1'b0, row} + (CW+1)'(2)) > (CW+1)'(drawable_rows_ff));

   logic             sa_valid_ff;
   bez_pkg::tag_type sa_tag_ff;
   logic [GA-1:0]    sa_c1_ff;
   logic [GA-1:0]    sa_r1_ff;
   logic [FW:0]      sa_t_ff;
   logic [FW:0]      sa_u_ff;
   logic [FW:0]      sa_ot_ff;
   logic [FW:0]      sa_ou_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= dv_valid;
      end
      sa_tag_ff.mode <= dv_tag.mode;
      sa_tag_ff.addr <= dv_tag.addr;
      sa_tag_ff.word <= dv_tag.word;
      sa_tag_ff.miss <= dv_tag.miss | cell_miss;
      sa_c1_ff       <= GA'(col[GA-1:0] * GA'(col_skip_ff));
      sa_r1_ff       <= GA'(row[GA-1:0] * cell_row_stride_ff);
      sa_t_ff        <= {1'b0, x_quot[FW-1:0]};
      sa_u_ff        <= {1'b0, y_quot[FW-1:0]};
      sa_ot_ff       <= (FW+1)'(1 << FW) - {1'b0, x_quot[FW-1:0]};
      sa_ou_ff       <= (FW+1)'(1 << FW) - {1'b0, y_quot[FW-1:0]};
   end

   // address stage: corner addresses wrap over the grid, weight products
   logic [GA-1:0] c2;
   logic [GA-1:0] r2;

   assign c2 = sa_c1_ff + GA'(col_skip_ff);
   assign r2 = sa_r1_ff + cell_row_stride_ff;

   logic             sb_valid_ff;
   bez_pkg::tag_type sb_tag_ff;
   logic [GA-1:0]    sb_addr_ff [4];
   logic [WW-1:0]    sb_w_ff    [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else begin
         sb_valid_ff <= sa_valid_ff;
      end
      sb_tag_ff     <= sa_tag_ff;
      sb_addr_ff[0] <= sa_r1_ff + sa_c1_ff;
      sb_addr_ff[1] <= sa_r1_ff + c2;
      sb_addr_ff[2] <= r2 + c2;
      sb_addr_ff[3] <= r2 + sa_c1_ff;
      // full weight reaches 2**32, so the product is formed at weight width
      sb_w_ff[0]    <= WW'(sa_ot_ff) * WW'(sa_ou_ff);
      sb_w_ff[1]    <= WW'(sa_t_ff) * WW'(sa_ou_ff);
      sb_w_ff[2]    <= WW'(sa_t_ff) * WW'(sa_u_ff);
      sb_w_ff[3]    <= WW'(sa_u_ff) * WW'(sa_ot_ff);
   end

   // grid copies: loads write all four here, in order with the queries' reads
   logic                                load_we;
   logic [3:0][bez_pkg::ELEV_W-1:0]     corner;

   assign load_we = sb_valid_ff & (sb_tag_ff.mode == bez_pkg::MODE_LOAD);

   for (genvar k = 0; k < 4; k++) begin : g_grid
      bez_ram #(
         .WIDTH(bez_pkg::ELEV_W),
         .DEPTH(bez_pkg::GRID_WORDS)
      ) u_ram (
         .clock  (clock),
         .wr_en  (load_we),
         .wr_addr(sb_tag_ff.addr),
         .wr_data(sb_tag_ff.word),
         .rd_addr(sb_addr_ff[k]),
         .rd_data(corner[k])
      );
   end

   // read stage: side data kept in step with the registered read
   bez_pkg::ctl_type            sc_ctl_ff;
   logic [3:0][WW-1:0]          sc_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ctl_ff <= '0;
      end else begin
         sc_ctl_ff.valid <= sb_valid_ff;
         sc_ctl_ff.query <= (sb_tag_ff.mode == bez_pkg::MODE_QUERY);
         sc_ctl_ff.miss  <= sb_tag_ff.miss;
      end
      for (int i = 0; i < 4; i++) begin
         sc_w_ff[i] <= sb_w_ff[i];
      end
   end

   // zero patch, weighted sum and final scaling
   bez_interp u_interp (
      .clock    (clock),
      .reset    (reset),
      .zero_fill(zero_fill_ff),
      .in_ctl   (sc_ctl_ff),
      .weight   (sc_w_ff),
      .corner   (corner),
      .rsp_valid(rsp_valid),
      .inside_ok(rsp_inside_ok),
      .elevation(rsp_elevation_q8)
   );
endmodule
`default_nettype wire

@@ rtl/bez_ram.sv @@
`default_nettype none
module bez_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ rtl/bez_div.sv @@
`default_nettype none
module bez_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire bez_pkg::tag_type                   in_tag,
   input  wire logic [bez_pkg::COORD_W-1:0]        x_num,
   input  wire logic [bez_pkg::COORD_W-1:0]        y_num,
   input  wire logic [bez_pkg::COORD_W-1:0]        cell_width,
   input  wire logic [bez_pkg::COORD_W-1:0]        cell_height,
   output logic                                    out_valid,
   output bez_pkg::tag_type                        out_tag,
   output logic [bez_pkg::QUOT_W-1:0]              x_quot,
   output logic [bez_pkg::QUOT_W-1:0]              y_quot
);
   localparam int N  = bez_pkg::DIV_STEPS;
   localparam int CW = bez_pkg::COORD_W;
   localparam int QW = bez_pkg::QUOT_W;
   localparam int SW = bez_pkg::DIV_ST_W;

   // one restoring step: {remainder, dividend/quotient shift word}
   function automatic logic [SW-1:0] div_step(input logic [SW-1:0] st,
                                              input logic [CW-1:0] dv);
      logic [CW:0] trial;
      logic [CW:0] diff;
      trial = {st[SW-1:QW], st[QW-1]};
      diff  = trial - {1'b0, dv};
      if (!diff[CW]) begin
         div_step = {diff[CW-1:0], st[QW-2:0], 1'b1};
      end else begin
         div_step = {trial[CW-1:0], st[QW-2:0], 1'b0};
      end
   endfunction

   logic             valid_ff [N];
   bez_pkg::tag_type tag_ff   [N];
   logic [SW-1:0]    xs_ff    [N];
   logic [SW-1:0]    ys_ff    [N];

   for (genvar g = 0; g < N; g++) begin : g_step
      logic             v_src;
      bez_pkg::tag_type t_src;
      logic [SW-1:0]    xs_src;
      logic [SW-1:0]    ys_src;

      if (g == 0) begin : g_first
         assign v_src  = in_valid;
         assign t_src  = in_tag;
         assign xs_src = {{CW{1'b0}}, x_num, {bez_pkg::FRAC_W{1'b0}}};
         assign ys_src = {{CW{1'b0}}, y_num, {bez_pkg::FRAC_W{1'b0}}};
      end else begin : g_next
         assign v_src  = valid_ff[g-1];
         assign t_src  = tag_ff[g-1];
         assign xs_src = xs_ff[g-1];
         assign ys_src = ys_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= v_src;
         end
         tag_ff[g] <= t_src;
         xs_ff[g]  <= div_step(xs_src, cell_width);
         ys_ff[g]  <= div_step(ys_src, cell_height);
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_tag   = tag_ff[N-1];
   assign x_quot    = xs_ff[N-1][QW-1:0];
   assign y_quot    = ys_ff[N-1][QW-1:0];
endmodule
`default_nettype wire

@@ rtl/bez_interp.sv @@
`default_nettype none
module bez_interp (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        zero_fill,
   input  wire bez_pkg::ctl_type                            in_ctl,
   input  wire logic [3:0][bez_pkg::WEIGHT_W-1:0]           weight,
   input  wire logic [3:0][bez_pkg::ELEV_W-1:0]             corner,
   output logic                                             rsp_valid,
   output logic                                             inside_ok,
   output logic signed [bez_pkg::OUT_W-1:0]                 elevation
);
   localparam int PW = bez_pkg::PE_W;
   localparam int WW = bez_pkg::WEIGHT_W;
   localparam int AW = bez_pkg::ACC_W;
   localparam int MW = bez_pkg::MAG_W;
   localparam int OW = bez_pkg::OUT_W;
   localparam int SH = bez_pkg::RECIP_SHIFT;

   // zero patch
   logic [3:0]           zero;
   logic [2:0]           nzero;
   logic signed [17:0]   csum;
   logic signed [PW-1:0] s1;
   logic signed [PW-1:0] s3;
   logic signed [PW-1:0] s6;
   logic signed [PW-1:0] base;
   logic signed [PW-1:0] pair;
   logic signed [PW-1:0] pe_in [4];

   always_comb begin
      nzero = '0;
      csum  = '0;
      base  = '0;
      pair  = '0;
      for (int i = 0; i < 4; i++) begin
         zero[i] = (corner[i] == '0);
         nzero   = nzero + {2'b00, zero[i]};
         csum    = csum + 18'($signed(corner[i]));
      end
      s1 = PW'(csum);
      s3 = (s1 <<< 1) + s1;
      s6 = s3 <<< 1;
      for (int i = 0; i < 4; i++) begin
         base = (PW'($signed(corner[i])) <<< 2) + (PW'($signed(corner[i])) <<< 1);
         pair = PW'($signed(corner[(i+1)&3])) + PW'($signed(corner[(i+3)&3]));
         pe_in[i] = base;
         if (zero_fill && zero[i]) begin
            case (nzero)
               3'd1:    pe_in[i] = (pair <<< 1) + pair;
               3'd2:    pe_in[i] = s3;
               3'd3:    pe_in[i] = s6;
               default: pe_in[i] = base;
            endcase
         end
      end
   end

   bez_pkg::ctl_type     p1_ctl_ff;
   logic signed [PW-1:0] p1_pe_ff [4];
   logic [WW-1:0]        p1_w_ff  [4];

   bez_pkg::ctl_type                      p2_ctl_ff;
   logic signed [bez_pkg::PROD_W-1:0]     p2_prod_ff [4];

   bez_pkg::ctl_type     p3_ctl_ff;
   logic signed [AW-1:0] p3_acc_ff;
   logic signed [AW-1:0] acc_in;

   bez_pkg::ctl_type     p4_ctl_ff;
   logic                 p4_neg_ff;
   logic [MW-1:0]        p4_mag_ff;
   logic [AW-1:0]        mag_full;

   bez_pkg::ctl_type     p5_ctl_ff;
   logic                 p5_neg_ff;
   logic [OW-1:0]        p5_q_ff;
   logic [MW+bez_pkg::RECIP_W-1:0] recip_prod;

   logic                 rsp_valid_ff;
   logic                 inside_ok_ff;
   logic signed [OW-1:0] elevation_ff;

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < 4; i++) begin
         acc_in = acc_in + AW'(p2_prod_ff[i]);
      end
      mag_full   = p3_acc_ff[AW-1] ? AW'(-p3_acc_ff) : AW'(p3_acc_ff);
      recip_prod = (MW+bez_pkg::RECIP_W)'(p4_mag_ff) * (MW+bez_pkg::RECIP_W)'(bez_pkg::RECIP6);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff    <= '0;
         p2_ctl_ff    <= '0;
         p3_ctl_ff    <= '0;
         p4_ctl_ff    <= '0;
         p5_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_ctl_ff.valid <= in_ctl.valid;
         p1_ctl_ff.query <= in_ctl.query;
         p1_ctl_ff.miss  <= in_ctl.miss | (zero_fill & (nzero == 3'd4));
         p2_ctl_ff       <= p1_ctl_ff;
         p3_ctl_ff       <= p2_ctl_ff;
         p4_ctl_ff       <= p3_ctl_ff;
         p5_ctl_ff       <= p4_ctl_ff;
         rsp_valid_ff    <= p5_ctl_ff.valid & p5_ctl_ff.query;
      end
      for (int i = 0; i < 4; i++) begin
         p1_pe_ff[i]   <= pe_in[i];
         p1_w_ff[i]    <= weight[i];
         p2_prod_ff[i] <= $signed({1'b0, p1_w_ff[i]}) * p1_pe_ff[i];
      end
      p3_acc_ff    <= acc_in;
      p4_neg_ff    <= p3_acc_ff[AW-1];
      p4_mag_ff    <= mag_full[MW+23:24];
      p5_neg_ff    <= p4_neg_ff;
      p5_q_ff      <= recip_prod[SH+OW-1:SH];
      inside_ok_ff <= ~p5_ctl_ff.miss;
      if (p5_ctl_ff.miss) begin
         elevation_ff <= '0;
      end else if (p5_neg_ff) begin
         elevation_ff <= -$signed(p5_q_ff);
      end else begin
         elevation_ff <= $signed(p5_q_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign inside_ok = inside_ok_ff;
   assign elevation = elevation_ff;
endmodule
`default_nettype wire

@@ rtl/bez_checker.sv @@
`default_nettype none
module bez_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               req_mode,
   input wire logic               rsp_valid,
   input wire logic               rsp_inside_ok,
   input wire logic signed [23:0] rsp_elevation_q8
);
   // a miss always reports zero elevation
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_ok |-> rsp_elevation_q8 == '0)
      else $error("miss with nonzero elevation");

   // every result comes from a query taken a fixed time earlier
   a_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_mode, bez_pkg::LATENCY))
      else $error("result without matching query");

   // a load never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_mode |-> ##(bez_pkg::LATENCY) !rsp_valid)
      else $error("result from a load");
endmodule

bind bilinear_elevation_zero_fill bez_checker u_checker (.*);
`default_nettype wire

@@ tb/tb_bilinear_elevation_zero_fill.sv @@
`default_nettype none
module tb_bilinear_elevation_zero_fill;
   import bez_pkg::*;

   localparam int IDLE_LIMIT   = 5000;   // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 60;     // covers the pipe depth, plus margin
   localparam int PHASE_WORDS  = 150;

   typedef struct {
      mode_type           mode;
      logic [15:0]        addr;
      logic signed [15:0] word;
      logic [23:0]        x;
      logic [23:0]        y;
   } grid_req_type;

   typedef struct {
      logic               inside_ok;
      logic signed [23:0] elev;
   } elev_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = 1'b0;
   logic [15:0] req_grid_address = '0;
   logic signed [15:0] req_elevation_word = '0;
   logic [23:0] req_x_pos = '0;
   logic [23:0] req_y_pos = '0;
   logic rsp_valid;
   logic rsp_inside_ok;
   logic signed [23:0] rsp_elevation_q8;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_CELL_WIDTH;
   logic [23:0] csr_wdata = '0;

   bilinear_elevation_zero_fill dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_grid_address, .req_elevation_word, .req_x_pos, .req_y_pos,
      .rsp_valid, .rsp_inside_ok, .rsp_elevation_q8,
      .csr_we, .csr_index, .csr_wdata
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor copy of the registers and grid
   longint cell_w = 256, cell_h = 256, top_y = 0, cols = 0, rows = 0;
   longint skip = 1, stride = 1;
   bit fill_on = 0;
   logic signed [15:0] grid_model [GRID_WORDS];
   bit loaded [GRID_WORDS];   // words written so far, as seen by the stimulus

   grid_req_type pending_q[$];
   elev_rsp_type elev_expect_q[$];
   int fails = 0;

   // map a point to its cell; returns 0 on a miss before the corner reads
   function automatic bit locate_cell(input logic [23:0] x, input logic [23:0] y,
                                      output logic [3:0][15:0] adr,
                                      output longint rx, output longint ry);
      longint col, row, d;
      adr = '0;
      rx = 0;
      ry = 0;
      if (cell_w == 0 || cell_h == 0 || longint'(y) > top_y) return 0;
      col = longint'(x) / cell_w;
      rx  = longint'(x) % cell_w;
      d   = top_y - longint'(y);
      row = d / cell_h;
      ry  = d % cell_h;
      if (col + 2 > cols || row + 2 > rows) return 0;
      // corners go around the cell: low/low, low/high, high/high, high/low
      adr[0] = 16'(row * stride + col * skip);
      adr[1] = 16'(row * stride + (col + 1) * skip);
      adr[2] = 16'((row + 1) * stride + (col + 1) * skip);
      adr[3] = 16'((row + 1) * stride + col * skip);
      return 1;
   endfunction

   function automatic elev_rsp_type interp_elevation(input grid_req_type q);
      elev_rsp_type r;
      logic [3:0][15:0] adr;
      longint rx, ry, t, u, ot, ou, acc, sum;
      longint e[4];
      int zeros;
      r.inside_ok = 1'b0;
      r.elev = '0;
      if (!locate_cell(q.x, q.y, adr, rx, ry)) return r;
      zeros = 0;
      for (int i = 0; i < 4; i++) begin
         e[i] = longint'(grid_model[adr[i]]) * 6;   // six times the value keeps means exact
         if (e[i] == 0) zeros++;
      end
      if (fill_on) begin
         if (zeros == 4) return r;
         if (zeros == 1) begin
            // lone zero takes the mean of the neighbors on either side of it
            for (int i = 0; i < 4; i++)
               if (e[i] == 0) e[i] = (e[(i + 1) % 4] + e[(i + 3) % 4]) / 2;
         end else if (zeros > 1) begin
            sum = e[0] + e[1] + e[2] + e[3];
            for (int i = 0; i < 4; i++)
               if (e[i] == 0) e[i] = sum / (4 - zeros);
         end
      end
      t  = (rx << 16) / cell_w;
      u  = (ry << 16) / cell_h;
      ot = 65536 - t;
      ou = 65536 - u;
      acc = ot * ou * e[0] + t * ou * e[1] + t * u * e[2] + u * ot * e[3];
      acc = acc / (longint'(6) << 24);
      r.inside_ok = 1'b1;
      r.elev = acc[23:0];
      return r;
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 0, gap_left = 0;
   bit drive_next;
   grid_req_type done_req;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            done_req = pending_q.pop_front();
            if (done_req.mode == MODE_LOAD) grid_model[done_req.addr] = done_req.word;
            else elev_expect_q.push_back(interp_elevation(done_req));
         end
         if (start && busy) begin
            drive_next = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            drive_next = 1'b0;
         end else if (pending_q.size() > 0) begin
            drive_next = 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            // some bursts run straight into the next one
            if (burst_left == 0) gap_left = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            drive_next = 1'b0;
         end
         start <= drive_next;
         if (drive_next) begin
            req_mode           <= pending_q[0].mode;
            req_grid_address   <= pending_q[0].addr;
            req_elevation_word <= pending_q[0].word;
            req_x_pos          <= pending_q[0].x;
            req_y_pos          <= pending_q[0].y;
         end
      end
   end

   // monitor
   elev_rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (elev_expect_q.size() == 0) begin
            $display("%0t: unexpected word inside_ok=%0b elevation=%0d",
                     $time, rsp_inside_ok, rsp_elevation_q8);
            fails++;
         end else begin
            want = elev_expect_q.pop_front();
            if (rsp_inside_ok !== want.inside_ok) begin
               $display("%0t: inside_ok expected %0b actual %0b",
                        $time, want.inside_ok, rsp_inside_ok);
               fails++;
            end
            if (rsp_elevation_q8 !== want.elev) begin
               $display("%0t: elevation_q8 expected %0d actual %0d",
                        $time, want.elev, rsp_elevation_q8);
               fails++;
            end
         end
      end
   end

   // watchdog on handshake activity
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else quiet_cycles <= quiet_cycles + 1;
   end

   // stimulus helpers
   int pushed;

   function automatic logic signed [15:0] pick_elev();
      case ($urandom % 6)
         0, 1: return 16'sd0;
         2: return 16'sh7FFF;
         3: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_load(input logic [15:0] a, input logic signed [15:0] w);
      grid_req_type q;
      q.mode = MODE_LOAD;
      q.addr = a;
      q.word = w;
      q.x = 24'($urandom);
      q.y = 24'($urandom);
      loaded[a] = 1'b1;
      pending_q.push_back(q);
      pushed++;
   endtask

   // a query, preceded by loads of any corner not yet written (of all corners if refresh)
   task automatic push_query(input logic [23:0] x, input logic [23:0] y, input bit refresh);
      grid_req_type q;
      logic [3:0][15:0] adr;
      longint rx, ry;
      if (locate_cell(x, y, adr, rx, ry))
         for (int i = 0; i < 4; i++)
            if (refresh || !loaded[adr[i]]) push_load(adr[i], pick_elev());
      q.mode = MODE_QUERY;
      q.addr = 16'($urandom);
      q.word = 16'($urandom);
      q.x = x;
      q.y = y;
      pending_q.push_back(q);
      pushed++;
   endtask

   // query a cell whose corners are loaded with the given values
   task automatic push_cell(input logic [23:0] x, input logic [23:0] y,
                            input logic signed [15:0] v0, input logic signed [15:0] v1,
                            input logic signed [15:0] v2, input logic signed [15:0] v3);
      logic [3:0][15:0] adr;
      longint rx, ry;
      void'(locate_cell(x, y, adr, rx, ry));
      push_load(adr[0], v0);
      push_load(adr[1], v1);
      push_load(adr[2], v2);
      push_load(adr[3], v3);
      push_query(x, y, 1'b0);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [23:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_CELL_WIDTH:      cell_w  = v;
         CSR_CELL_HEIGHT:     cell_h  = v;
         CSR_REGION_TOP:      top_y   = v;
         CSR_DRAWABLE_COLS:   cols    = v[15:0];
         CSR_DRAWABLE_ROWS:   rows    = v[15:0];
         CSR_COL_SKIP:        skip    = v[7:0];
         CSR_CELL_ROW_STRIDE: stride  = v[15:0];
         default:             fill_on = v[0];
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(input longint w, input longint h, input longint ty,
                           input longint c, input longint r, input longint sk,
                           input longint st, input bit zf);
      csr_write(CSR_CELL_WIDTH, 24'(w));
      csr_write(CSR_CELL_HEIGHT, 24'(h));
      csr_write(CSR_REGION_TOP, 24'(ty));
      csr_write(CSR_DRAWABLE_COLS, 24'(c));
      csr_write(CSR_DRAWABLE_ROWS, 24'(r));
      csr_write(CSR_COL_SKIP, 24'(sk));
      csr_write(CSR_CELL_ROW_STRIDE, 24'(st));
      csr_write(CSR_ZERO_FILL, 24'(zf));
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_q.size() > 0 || start || elev_expect_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random words: mostly points that land in the drawable area
   task automatic random_phase();
      longint span_x, span_y, x, y;
      pushed = 0;
      while (pushed < PHASE_WORDS) begin
         case ($urandom % 10)
            8: push_load(16'($urandom), pick_elev());
            9: push_query(24'($urandom), 24'($urandom), 1'b0);
            default: begin
               span_x = (cols >= 2) ? (cols - 1) * cell_w : 1;
               span_y = (rows >= 2) ? (rows - 1) * cell_h : 1;
               if (span_x > 24'hFFFFFF) span_x = 24'hFFFFFF;
               if (span_x < 1) span_x = 1;
               if (span_y > top_y + 1) span_y = top_y + 1;
               if (span_y < 1) span_y = 1;
               x = longint'($urandom) % span_x;
               y = top_y - longint'($urandom) % span_y;
               // about one query in four rewrites its corners for fresh zero patterns
               push_query(24'(x), 24'(y), $urandom % 4 == 0);
            end
         endcase
      end
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: nothing is drawable
      push_load(16'hFFFF, 16'sh7FFF);
      push_load(16'h0000, 16'sh8000);
      push_query(24'h000000, 24'h000000, 1'b0);
      push_query(24'hFFFFFF, 24'hFFFFFF, 1'b0);
      wait_idle();

      // zero-fill patterns on a small grid, fill on then off
      for (int zf = 1; zf >= 0; zf--) begin
         set_regs(256, 256, 24'h800, 8, 8, 1, 16, zf[0]);
         push_cell(24'h180, 24'h700, 100, 200, 300, 400);
         push_cell(24'h180, 24'h700, 0, -200, 300, 401);       // one zero corner
         push_cell(24'h280, 24'h640, 0, 0, 7, -3);             // two zero corners
         push_cell(24'h2C0, 24'h5F0, 5, 0, 0, 0);              // three zero corners
         push_cell(24'h1FF, 24'h7FF, 0, 0, 0, 0);              // all zero
         push_cell(24'h5FF, 24'h101, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
         push_query(24'h800, 24'h700, 1'b0);                   // past the last column
         push_query(24'h100, 24'h801, 1'b0);                   // above the region top
         wait_idle();
      end

      // extremes of the registers, wrapping addresses, zero cell width and height
      set_regs(1, 1, 24'hFFFFFF, 65535, 65535, 255, 65535, 1);
      random_phase();
      set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 65535, 65535, 1, 1, 0);
      push_query(24'hFFFFFF, 24'h000000, 1'b0);
      random_phase();
      set_regs(0, 256, 24'h4000, 64, 64, 3, 200, 1);
      random_phase();
      set_regs(256, 0, 24'h4000, 64, 64, 3, 200, 0);
      random_phase();

      for (int p = 0; p < 7; p++) begin
         set_regs($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom,
                  $urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(1, 255),
                  $urandom_range(1, 65535), $urandom % 2);
         random_phase();
      end

      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
`default_nettype wire
